// ===== rtl/skp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skp_pkg
// Shared constants and codes for the sparse Kronecker product block.
// ----------------------------------------------------------------------------
package skp_pkg;

    localparam int MAX_B_ENTRIES = 64;
    localparam int ADDR_BITS     = $clog2(MAX_B_ENTRIES);
    localparam int CNT_BITS      = $clog2(MAX_B_ENTRIES + 1);
    localparam int INDEX_BITS    = 16;
    localparam int VALUE_BITS    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int CFG_BITS      = 17;
    localparam int CFG_IDX_BITS  = 2;
    localparam int OUT_IDX_BITS  = 32;
    localparam int MUL_BITS      = 33;
    localparam int PROD_BITS     = 2 * VALUE_BITS;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_EXPAND = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_BITS-1:0] CFG_B_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B_COLS = 2'd1;

endpackage

// ===== rtl/sparse_kronecker_product_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_kronecker_product_top
// Kronecker product of two sparse matrices held as coordinate triplets.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ---------------------------------
// input     in         i_valid / o_stall        i_kind, i_row, i_col, i_value
// output    out        o_valid / i_stall        o_out_row, o_out_col, o_out_value,
//                                               o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load or clear item is handled directly in the idle state. An expand item
// first forms the scaled row base and then the scaled column base on the
// shared multiplier, then issues one stored entry per cycle while the output
// does not stall, through a three-stage pipeline (store read, multiply,
// shift and saturate); the single shared multiplier and the one read port
// of the entry store set that rate. A stall on the output while o_valid is
// high freezes the whole pipeline in place. Reset (i_rst_n low, synchronous)
// empties the store and sets both size registers to one; it needs no
// clearing pass. The input is stalled from the moment an expand item is
// taken until its last transfer has moved into the output register.
//
module sparse_kronecker_product_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_kind,
    input  logic [skp_pkg::INDEX_BITS-1:0]      i_row,
    input  logic [skp_pkg::INDEX_BITS-1:0]      i_col,
    input  logic signed [skp_pkg::VALUE_BITS-1:0] i_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [skp_pkg::OUT_IDX_BITS-1:0]    o_out_row,
    output logic [skp_pkg::OUT_IDX_BITS-1:0]    o_out_col,
    output logic signed [skp_pkg::VALUE_BITS-1:0] o_out_value,
    output logic                                o_last,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [skp_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import skp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_ROW,
        ST_MUL_COL,
        ST_STREAM
    } t_state;

    localparam int ENTRY_BITS = 2 * INDEX_BITS + VALUE_BITS;

    localparam logic signed [PROD_BITS-1:0] SAT_HI =
        {{(PROD_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [PROD_BITS-1:0] SAT_LO = ~SAT_HI;

    // Entry store: row, column and value of each loaded second-matrix entry.
    logic [ENTRY_BITS-1:0] r_mem [MAX_B_ENTRIES];
    logic [ENTRY_BITS-1:0] r_rd_data;

    t_state                     r_state;
    logic [CNT_BITS-1:0]        r_count;
    logic [CNT_BITS-1:0]        r_issue_idx;
    logic [CNT_BITS-1:0]        n_issue_idx;
    logic [CFG_BITS-1:0]        r_b_rows;
    logic [CFG_BITS-1:0]        r_b_cols;

    // First-matrix entry being expanded and its scaled bases.
    logic [INDEX_BITS-1:0]      r_a_row;
    logic [INDEX_BITS-1:0]      r_a_col;
    logic signed [VALUE_BITS-1:0] r_a_val;
    logic [OUT_IDX_BITS-1:0]    r_base_row;
    logic [OUT_IDX_BITS-1:0]    r_base_col;

    // Pipeline stages.
    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic                       r_s2_valid;
    logic                       r_s2_last;
    logic [OUT_IDX_BITS-1:0]    r_s2_row;
    logic [OUT_IDX_BITS-1:0]    r_s2_col;
    logic signed [PROD_BITS-1:0] r_s2_prod;

    logic                       w_in_take;
    logic                       w_adv;
    logic                       w_issue;
    logic                       w_issue_last;
    logic [INDEX_BITS-1:0]      w_rd_row;
    logic [INDEX_BITS-1:0]      w_rd_col;
    logic signed [VALUE_BITS-1:0] w_rd_val;
    logic signed [MUL_BITS-1:0] w_mul_a;
    logic signed [MUL_BITS-1:0] w_mul_b;
    logic signed [2*MUL_BITS-1:0] w_mul_p;
    logic signed [PROD_BITS-1:0] w_shifted;
    logic signed [VALUE_BITS-1:0] w_sat;

    // The input is taken only when the sequencer is idle and no issued entry
    // is still ahead of the output register.
    assign o_stall     = !((r_state == ST_IDLE) && !r_s1_valid && !r_s2_valid);
    assign w_in_take   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // The pipeline moves whenever the output register is free or being taken.
    assign w_adv        = !o_valid || !i_stall;
    assign w_issue      = (r_state == ST_STREAM) && w_adv;
    assign n_issue_idx  = r_issue_idx + 1'b1;
    assign w_issue_last = (n_issue_idx == r_count);

    assign w_rd_row = r_rd_data[ENTRY_BITS-1 -: INDEX_BITS];
    assign w_rd_col = r_rd_data[VALUE_BITS +: INDEX_BITS];
    assign w_rd_val = $signed(r_rd_data[VALUE_BITS-1:0]);

    // Shared multiplier: forms the two scaled bases during setup, then the
    // value products while streaming.
    always_comb begin
        case (r_state)
            ST_MUL_ROW: begin
                w_mul_a = $signed({{(MUL_BITS-INDEX_BITS){1'b0}}, r_a_row});
                w_mul_b = $signed({{(MUL_BITS-CFG_BITS){1'b0}}, r_b_rows});
            end
            ST_MUL_COL: begin
                w_mul_a = $signed({{(MUL_BITS-INDEX_BITS){1'b0}}, r_a_col});
                w_mul_b = $signed({{(MUL_BITS-CFG_BITS){1'b0}}, r_b_cols});
            end
            default: begin
                w_mul_a = {{(MUL_BITS-VALUE_BITS){r_a_val[VALUE_BITS-1]}}, r_a_val};
                w_mul_b = {{(MUL_BITS-VALUE_BITS){w_rd_val[VALUE_BITS-1]}}, w_rd_val};
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Arithmetic shift rounds toward minus infinity, then clamp to the
    // signed output range.
    assign w_shifted = r_s2_prod >>> FRAC_BITS;

    always_comb begin
        if (w_shifted > SAT_HI) begin
            w_sat = SAT_HI[VALUE_BITS-1:0];
        end else if (w_shifted < SAT_LO) begin
            w_sat = SAT_LO[VALUE_BITS-1:0];
        end else begin
            w_sat = w_shifted[VALUE_BITS-1:0];
        end
    end

    // Entry store write on a load and registered read for the stream.
    always_ff @(posedge i_clk) begin
        if (w_in_take && (i_kind == KIND_LOAD) && (r_count < CNT_BITS'(MAX_B_ENTRIES))) begin
            r_mem[r_count[ADDR_BITS-1:0]] <= {i_row, i_col, i_value};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_issue_idx[ADDR_BITS-1:0]];
        end
    end

    // Sequencer, configuration and pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue_idx <= '0;
            r_b_rows    <= CFG_BITS'(1);
            r_b_cols    <= CFG_BITS'(1);
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_B_ROWS) begin
                    r_b_rows <= i_cfg_data;
                end else if (i_cfg_index == CFG_B_COLS) begin
                    r_b_cols <= i_cfg_data;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        if (i_kind == KIND_LOAD) begin
                            if (r_count < CNT_BITS'(MAX_B_ENTRIES)) begin
                                r_count <= r_count + 1'b1;
                            end
                        end else if (i_kind == KIND_CLEAR) begin
                            r_count <= '0;
                        end else if ((i_kind == KIND_EXPAND) && (r_count != '0)) begin
                            r_state <= ST_MUL_ROW;
                        end
                    end
                end
                ST_MUL_ROW: begin
                    r_base_row <= w_mul_p[OUT_IDX_BITS-1:0];
                    r_state    <= ST_MUL_COL;
                end
                ST_MUL_COL: begin
                    r_base_col  <= w_mul_p[OUT_IDX_BITS-1:0];
                    r_issue_idx <= '0;
                    r_state     <= ST_STREAM;
                end
                ST_STREAM: begin
                    if (w_issue) begin
                        r_issue_idx <= n_issue_idx;
                        if (w_issue_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_adv) begin
                r_s1_valid <= w_issue;
                r_s2_valid <= r_s1_valid;
                o_valid    <= r_s2_valid;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_take && (i_kind == KIND_EXPAND)) begin
            r_a_row <= i_row;
            r_a_col <= i_col;
            r_a_val <= i_value;
        end
        if (w_adv) begin
            r_s1_last   <= w_issue_last;
            r_s2_last   <= r_s1_last;
            r_s2_row    <= r_base_row + {{(OUT_IDX_BITS-INDEX_BITS){1'b0}}, w_rd_row};
            r_s2_col    <= r_base_col + {{(OUT_IDX_BITS-INDEX_BITS){1'b0}}, w_rd_col};
            r_s2_prod   <= w_mul_p[PROD_BITS-1:0];
            o_out_row   <= r_s2_row;
            o_out_col   <= r_s2_col;
            o_out_value <= w_sat;
            o_last      <= r_s2_last;
        end
    end

endmodule
